/* rtl/core/tridiagonal_thomas_solver_defines.svh */
// Assertion macros shared by the solver RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_DEFINES_SVH

// Same-cycle implication
`define TTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tts_pkg.sv */
// Package for the tridiagonal solver: sizes, payload structs, divider link, FSM states.
// No dependencies.
package tts_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int ROW_W     = 6;
	localparam int ADDR_W    = $clog2(MAX_ROWS);

	// One row of the system
	typedef struct packed {
		logic signed [DATA_W-1:0] sub_coef;
		logic signed [DATA_W-1:0] diag_coef;
		logic signed [DATA_W-1:0] super_coef;
		logic signed [DATA_W-1:0] rhs_value;
		logic                     last_row;
	} row_req_t;

	// One solved unknown
	typedef struct packed {
		logic signed [DATA_W-1:0] solution_value;
		logic [ROW_W-1:0]         row_index;
		logic                     last_result;
		logic                     singular;
	} sol_res_t;

	// Classified row handed from front to back
	typedef struct packed {
		row_req_t          req;
		logic [ADDR_W-1:0] row;
		logic              final_row;
	} row_cmd_t;

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] dividend;
		logic signed [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [DATA_W-1:0] quotient;
		logic                     ovf;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TAKE,
		ST_DIVM,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_LAST,
		ST_DIVL,
		ST_BRD,
		ST_BM1,
		ST_BM2,
		ST_BSUB,
		ST_BDIV,
		ST_ORD,
		ST_OLD,
		ST_OWAIT
	} back_st_t;

endpackage

/* rtl/core/tts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/tts_div.sv */
// Iterative signed fixed-point divider, two quotient bits per cycle, saturating.
// Depends on tts_pkg.
module tts_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tts_pkg::div_req_t req,
	output tts_pkg::div_rsp_t rsp
);
	import tts_pkg::*;

	localparam int DW    = DATA_W + FRAC_BITS;
	localparam int STEPS = 2;
	localparam int ITER  = (DW + STEPS - 1) / STEPS;
	localparam int PW    = ITER * STEPS;
	localparam int CW    = $clog2(ITER + 1);

	logic              busy_q, done_q, ovf_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     dvd_q, quo_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] dvs_q, res_q;

	logic [DATA_W-1:0] mag_a, mag_b;
	logic [DATA_W:0]   rem_n;
	logic [PW-1:0]     dvd_n, quo_n;
	logic              last_iter;
	logic              sat_hi;
	logic [DATA_W-1:0] res_n;

	assign mag_a = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign mag_b = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign last_iter = (cnt_q == CW'(ITER));

	// Restoring steps on magnitudes
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		quo_n = quo_q;
		for (int k = 0; k < STEPS; k++) begin
			rem_n = {rem_n[DATA_W-1:0], dvd_n[PW-1]};
			dvd_n = {dvd_n[PW-2:0], 1'b0};
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_n = rem_n - {1'b0, dvs_q};
				quo_n = {quo_n[PW-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[PW-2:0], 1'b0};
			end
		end
	end

	// Sign and saturation of the finished quotient
	always_comb begin
		if (neg_q) begin
			sat_hi = quo_q > PW'(33'h080000000);
			res_n  = sat_hi ? 32'h80000000 : (~quo_q[DATA_W-1:0] + 1'b1);
		end else begin
			sat_hi = quo_q > PW'(32'h7FFFFFFF);
			res_n  = sat_hi ? 32'h7FFFFFFF : quo_q[DATA_W-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last_iter) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= PW'({mag_a, {FRAC_BITS{1'b0}}});
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= mag_b;
			neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
		end else if (busy_q && !last_iter) begin
			dvd_q <= dvd_n;
			quo_q <= quo_n;
			rem_q <= rem_n;
		end else if (busy_q) begin
			res_q <= res_n;
			ovf_q <= sat_hi;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;
	assign rsp.ovf      = ovf_q;

endmodule

/* rtl/core/tts_front.sv */
// Front end: accepts row requests, numbers and classifies them, queues them for the back end.
// Depends on tts_pkg.
module tts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              row_valid,
	output logic              row_stall,
	input  tts_pkg::row_req_t row_data,
	output logic              cmd_valid,
	output tts_pkg::row_cmd_t cmd,
	input  logic              cmd_take
);
	import tts_pkg::*;

	localparam int QD = 2;
	localparam int PW = $clog2(QD);
	localparam int CW = $clog2(QD + 1);

	row_cmd_t          ents_q [QD];
	logic [PW-1:0]     wp_q, rp_q;
	logic [CW-1:0]     cnt_q;
	logic [ADDR_W-1:0] rc_q;
	logic              acc, fin;

	assign row_stall = (cnt_q == CW'(QD));
	assign acc       = row_valid && !row_stall;
	// Full store forces the end of the system
	assign fin       = row_data.last_row || (rc_q == ADDR_W'(MAX_ROWS - 1));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ents_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			rc_q  <= '0;
		end else begin
			if (acc) begin
				wp_q <= (wp_q == PW'(QD - 1)) ? '0 : wp_q + 1'b1;
				rc_q <= fin ? '0 : rc_q + 1'b1;
			end
			if (cmd_take) begin
				rp_q <= (rp_q == PW'(QD - 1)) ? '0 : rp_q + 1'b1;
			end
			if (acc && !cmd_take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!acc && cmd_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ents_q[wp_q] <= row_cmd_t'{req: row_data, row: rc_q, final_row: fin};
		end
	end

endmodule

/* rtl/core/tts_back.sv */
// Back end: forward elimination, back substitution and result output.
// Depends on tts_pkg, tts_ram; uses the shared divider through div_req/div_rsp.
module tts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  tts_pkg::row_cmd_t cmd,
	output logic              cmd_take,
	output tts_pkg::div_req_t div_req,
	input  tts_pkg::div_rsp_t div_rsp,
	output logic              sol_valid,
	input  logic              sol_stall,
	output tts_pkg::sol_res_t sol_data
);
	import tts_pkg::*;

	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	back_st_t state_q, state_d;
	row_cmd_t cmd_q;
	sol_res_t out_q;
	logic     out_valid_q, fault_q, fault_set;

	logic signed [DATA_W-1:0] m_q, prev_piv_q, prev_rhs_q, prev_sup_q, cur_piv_q;
	logic signed [DATA_W-1:0] mres_q, x_q, bp_q, br_q;
	logic signed [63:0]       prod_q;
	logic [ADDR_W-1:0]        i_q, o_q, n_q;

	logic signed [DATA_W-1:0] mul_x, mul_y;
	logic [DATA_W:0]          mr, piv_s, rhs_s, num_s;
	logic                     st_we, sol_we;
	logic [ADDR_W-1:0]        sol_waddr;
	logic [DATA_W-1:0]        piv_wd, rhs_wd, sup_wd, sol_wd;
	logic [DATA_W-1:0]        piv_rd, rhs_rd, sup_rd, sol_rd;
	logic                     back_next;

	// Round half up by FRAC_BITS, saturate; returns {ovf, value}
	function automatic logic [DATA_W:0] rnd_sat(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (t > SMAX) begin
			return {1'b1, SMAX[DATA_W-1:0]};
		end else if (t < SMIN) begin
			return {1'b1, SMIN[DATA_W-1:0]};
		end
		return {1'b0, t[DATA_W-1:0]};
	endfunction

	// a - b with saturation; returns {ovf, value}
	function automatic logic [DATA_W:0] sub_sat(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1]) begin
			return {1'b1, d[DATA_W] ? SMIN[DATA_W-1:0] : SMAX[DATA_W-1:0]};
		end
		return {1'b0, d[DATA_W-1:0]};
	endfunction

	// Stores
	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_piv_ram (
		.clk(clk), .we(st_we), .waddr(cmd_q.row), .wdata(piv_wd), .raddr(i_q), .rdata(piv_rd));
	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
		.clk(clk), .we(st_we), .waddr(cmd_q.row), .wdata(rhs_wd), .raddr(i_q), .rdata(rhs_rd));
	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_sup_ram (
		.clk(clk), .we(st_we), .waddr(cmd_q.row), .wdata(sup_wd), .raddr(i_q), .rdata(sup_rd));
	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_sol_ram (
		.clk(clk), .we(sol_we), .waddr(sol_waddr), .wdata(sol_wd), .raddr(o_q), .rdata(sol_rd));

	// Shared multiplier operands
	always_comb begin
		case (state_q)
			ST_M2:   begin mul_x = m_q;             mul_y = prev_rhs_q; end
			ST_BM1:  begin mul_x = $signed(sup_rd); mul_y = x_q;        end
			default: begin mul_x = m_q;             mul_y = prev_sup_q; end
		endcase
	end

	assign mr    = rnd_sat(prod_q);
	assign piv_s = sub_sat(cmd_q.req.diag_coef, mres_q);
	assign rhs_s = sub_sat(cmd_q.req.rhs_value, mres_q);
	assign num_s = sub_sat(br_q, mres_q);

	// Next state and strobes
	always_comb begin
		state_d         = state_q;
		cmd_take        = 1'b0;
		div_req.start   = 1'b0;
		div_req.dividend = cmd_q.req.sub_coef;
		div_req.divisor  = prev_piv_q;
		st_we     = 1'b0;
		piv_wd    = cur_piv_q;
		rhs_wd    = rhs_s[DATA_W-1:0];
		sup_wd    = cmd_q.req.super_coef;
		sol_we    = 1'b0;
		sol_waddr = i_q;
		sol_wd    = div_rsp.quotient;
		fault_set = 1'b0;
		back_next = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					state_d  = ST_TAKE;
				end
			end
			ST_TAKE: begin
				if (cmd_q.row == '0) begin
					st_we   = 1'b1;
					piv_wd  = cmd_q.req.diag_coef;
					rhs_wd  = cmd_q.req.rhs_value;
					state_d = ST_LAST;
				end else if (prev_piv_q == '0) begin
					fault_set = 1'b1;
					state_d   = ST_M1;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIVM;
				end
			end
			ST_DIVM: begin
				if (div_rsp.done) begin
					fault_set = div_rsp.ovf;
					state_d   = ST_M1;
				end
			end
			ST_M1: state_d = ST_M2;
			ST_M2: begin
				fault_set = mr[DATA_W];
				state_d   = ST_M3;
			end
			ST_M3: begin
				fault_set = mr[DATA_W] || piv_s[DATA_W];
				state_d   = ST_M4;
			end
			ST_M4: begin
				st_we     = 1'b1;
				fault_set = rhs_s[DATA_W];
				state_d   = ST_LAST;
			end
			ST_LAST: begin
				sol_waddr = cmd_q.row;
				sol_wd    = '0;
				if (!cmd_q.final_row) begin
					state_d = ST_IDLE;
				end else if (prev_piv_q == '0) begin
					// zero last pivot: solution zero, no fault
					sol_we  = 1'b1;
					state_d = (cmd_q.row == '0) ? ST_ORD : ST_BRD;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = prev_rhs_q;
					state_d          = ST_DIVL;
				end
			end
			ST_DIVL: begin
				sol_waddr = cmd_q.row;
				if (div_rsp.done) begin
					sol_we    = 1'b1;
					fault_set = div_rsp.ovf;
					state_d   = (cmd_q.row == '0) ? ST_ORD : ST_BRD;
				end
			end
			ST_BRD: state_d = ST_BM1;
			ST_BM1: state_d = ST_BM2;
			ST_BM2: begin
				fault_set = mr[DATA_W];
				state_d   = ST_BSUB;
			end
			ST_BSUB: begin
				if (bp_q == '0) begin
					sol_we    = 1'b1;
					sol_wd    = '0;
					fault_set = 1'b1;
					back_next = 1'b1;
				end else begin
					fault_set        = num_s[DATA_W];
					div_req.start    = 1'b1;
					div_req.dividend = num_s[DATA_W-1:0];
					div_req.divisor  = bp_q;
					state_d          = ST_BDIV;
				end
			end
			ST_BDIV: begin
				if (div_rsp.done) begin
					sol_we    = 1'b1;
					fault_set = div_rsp.ovf;
					back_next = 1'b1;
				end
			end
			ST_ORD: state_d = ST_OLD;
			ST_OLD: state_d = ST_OWAIT;
			ST_OWAIT: begin
				if (!sol_stall) begin
					state_d = (o_q == n_q) ? ST_IDLE : ST_ORD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (back_next) begin
			state_d = (i_q == '0) ? ST_ORD : ST_BRD;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OLD) begin
				out_valid_q <= 1'b1;
			end else if (state_q == ST_OWAIT && !sol_stall) begin
				out_valid_q <= 1'b0;
			end
			// run ends when its final result is taken
			if (state_q == ST_OWAIT && !sol_stall && o_q == n_q) begin
				fault_q <= 1'b0;
			end else if (fault_set) begin
				fault_q <= 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			ST_TAKE: begin
				m_q <= '0;
				if (cmd_q.row == '0) begin
					prev_piv_q <= cmd_q.req.diag_coef;
					prev_rhs_q <= cmd_q.req.rhs_value;
					prev_sup_q <= cmd_q.req.super_coef;
				end
			end
			ST_DIVM: begin
				if (div_rsp.done) begin
					m_q <= div_rsp.quotient;
				end
			end
			ST_M2: mres_q <= mr[DATA_W-1:0];
			ST_M3: begin
				cur_piv_q <= piv_s[DATA_W-1:0];
				mres_q    <= mr[DATA_W-1:0];
			end
			ST_M4: begin
				prev_piv_q <= cur_piv_q;
				prev_rhs_q <= rhs_s[DATA_W-1:0];
				prev_sup_q <= cmd_q.req.super_coef;
			end
			ST_LAST: begin
				n_q <= cmd_q.row;
				i_q <= cmd_q.row - 1'b1;
				o_q <= '0;
				x_q <= '0;
			end
			ST_DIVL: begin
				if (div_rsp.done) begin
					x_q <= div_rsp.quotient;
				end
			end
			ST_BM1: begin
				bp_q <= $signed(piv_rd);
				br_q <= $signed(rhs_rd);
			end
			ST_BM2: mres_q <= mr[DATA_W-1:0];
			ST_BSUB: begin
				if (bp_q == '0) begin
					x_q <= '0;
					i_q <= i_q - 1'b1;
				end
			end
			ST_BDIV: begin
				if (div_rsp.done) begin
					x_q <= div_rsp.quotient;
					i_q <= i_q - 1'b1;
				end
			end
			ST_OLD: begin
				out_q.solution_value <= $signed(sol_rd);
				out_q.row_index      <= ROW_W'(o_q);
				out_q.last_result    <= (o_q == n_q);
				out_q.singular       <= fault_q;
			end
			ST_OWAIT: begin
				if (!sol_stall) begin
					o_q <= o_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign sol_valid = out_valid_q;
	assign sol_data  = out_q;

endmodule

/* rtl/core/tridiagonal_thomas_solver.sv */
// Tridiagonal system solver (Thomas algorithm), Q16.16, top level.
// Depends on tts_pkg, tts_front, tts_back, tts_div, tts_ram and the defines header.
//
// Usage: send the rows of a system on row_valid/row_stall/row_data, row 0 first,
// with last_row set on the final row; the 64th row ends a system by itself.
// Each row request is taken when row_valid is high and row_stall low; a two-entry
// queue keeps taking rows while the solver works.
// Forward elimination of each row is bounded by the shared
// two-bits-per-cycle divider. After the final row, back substitution
// is again bounded by the divider.
// Results then leave on sol_valid/sol_stall/sol_data in ascending row order,
// one at a time, each read only after the previous one is taken; last_result marks the end
// and singular is the same on every result of the system.
// A stalled result holds in the output register; the back end waits on it while
// the front end keeps queuing rows of the next system.
// Reset (arst_n low) empties the queue and drops any partial system; the stores
// need no clearing.
`include "tridiagonal_thomas_solver_defines.svh"

module tridiagonal_thomas_solver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              row_valid,
	output logic              row_stall,
	input  tts_pkg::row_req_t row_data,
	output logic              sol_valid,
	input  logic              sol_stall,
	output tts_pkg::sol_res_t sol_data
);
	import tts_pkg::*;

	row_cmd_t cmd;
	logic     cmd_valid, cmd_take;
	div_req_t div_req;
	div_rsp_t div_rsp;

	tts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_stall(row_stall), .row_data(row_data),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	tts_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
		.div_req(div_req), .div_rsp(div_rsp),
		.sol_valid(sol_valid), .sol_stall(sol_stall), .sol_data(sol_data)
	);

	tts_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	// Checks
	`TTS_ASSERT_IMP(a_div_idle, div_req.start, !div_rsp.busy && !div_rsp.done, "divider restarted while busy")
	`TTS_ASSERT_IMP(a_take_valid, cmd_take, cmd_valid, "back end took from an empty queue")
	`TTS_ASSERT_NXT(a_sol_gap, sol_valid && !sol_stall, !sol_valid, "result repeated after it was taken")

endmodule
